>>> src/stkt_pkg.sv
package stkt_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = CNT_W + 9;
  localparam int GROUP = 16;
  localparam int NGRP  = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [63:0] host_id;
    logic [31:0] period_start;
    logic [63:0] maint_id;
    logic        maint_kind;
    logic [63:0] host_cur_maint_id;
    logic        host_cur_status;
    logic        host_cur_kind;
    logic [30:0] host_cur_since;
  } entry_t;

  // shared control seen by every cell
  typedef struct packed {
    cmd_t             cmd;
    entry_t           ent;
    logic [7:0]       read_index;
    logic [CNT_W-1:0] count;
    logic             cmp_en;
    logic             sel_en;
    logic             do_write;
  } cell_bc_t;

  // per-cell contribution to the result, zero unless selected
  typedef struct packed {
    entry_t           entry;
    logic [IDX_W-1:0] pidx;
    logic             place;
  } cell_out_t;

endpackage

>>> src/stkt_cell.sv
module stkt_cell (
  input  logic                    clk,
  input  logic [stkt_pkg::IDX_W-1:0] idx,
  input  stkt_pkg::cell_bc_t      bc,
  input  logic                    prev_below,
  input  stkt_pkg::entry_t        prev_ent,
  output logic                    below,
  output stkt_pkg::entry_t        ent,
  output logic                    hit,
  output stkt_pkg::cell_out_t     sel_q
);
  import stkt_pkg::*;

  logic in_range;
  logic in_le;
  logic key_below;
  logic key_equal;
  logic eq_q;
  logic is_place;
  logic shift;
  logic rd_sel;
  logic pick;

  assign in_range = CNT_W'(idx) < bc.count;
  assign in_le    = CNT_W'(idx) <= bc.count;

  always_comb begin
    if (ent.host_id != bc.ent.host_id) begin
      key_below = ent.host_id < bc.ent.host_id;
    end else if (ent.period_start != bc.ent.period_start) begin
      key_below = ent.period_start < bc.ent.period_start;
    end else begin
      key_below = ent.maint_id < bc.ent.maint_id;
    end
  end

  assign key_equal = (ent.host_id == bc.ent.host_id) &&
                     (ent.period_start == bc.ent.period_start) &&
                     (ent.maint_id == bc.ent.maint_id);

  always_ff @(posedge clk) begin
    if (bc.cmp_en) begin
      below <= in_range && key_below;
      eq_q  <= in_range && key_equal;
    end
  end

  // below bits form a prefix; the place is the first cell past it
  assign is_place = prev_below && !below;
  assign shift    = !prev_below && in_le;
  assign hit      = is_place && eq_q;
  assign rd_sel   = (bc.cmd == CMD_READ) && in_range &&
                    (CMP_W'(idx) == CMP_W'(bc.read_index));
  assign pick     = ((bc.cmd == CMD_INSERT) && hit) || rd_sel;

  always_ff @(posedge clk) begin
    if (bc.sel_en) begin
      sel_q.entry <= pick ? ent : '0;
      sel_q.pidx  <= (is_place && in_le) ? idx : '0;
      sel_q.place <= is_place && in_le;
    end
    if (bc.do_write) begin
      if (shift) begin
        ent <= prev_ent;
      end else if (is_place && in_le) begin
        ent <= bc.ent;
      end
    end
  end

endmodule

>>> src/stkt_reduce.sv
module stkt_reduce (
  input  logic                clk,
  input  logic                en,
  input  stkt_pkg::cell_out_t cells [stkt_pkg::DEPTH],
  output stkt_pkg::cell_out_t grp   [stkt_pkg::NGRP]
);
  import stkt_pkg::*;

  cell_out_t grp_next [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          grp_next[g] = cell_out_t'(grp_next[g] | cells[g * GROUP + k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp <= grp_next;
    end
  end

endmodule

>>> src/sorted_triple_key_table_insert_core.sv
// channel | handshake            | payload
// input   | in_valid / in_stall  | command, key, payload fields, read_index
// output  | out_valid / out_stall| position, flags, entry_count, out_* entry
//
// Every command passes through accept, compare in all cells, select/shift,
// group reduce, final reduce into the output register. The last step waits
// while a previous result is still held under out_stall.
// The next item is accepted once the engine is idle, even with a result held.
// Reset clears the state, the entry count and out_valid; cell contents stay undefined.
module sorted_triple_key_table_insert_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] host_id,
  input  logic [31:0] period_start,
  input  logic [63:0] maint_id,
  input  logic        maint_kind,
  input  logic [63:0] host_cur_maint_id,
  input  logic        host_cur_status,
  input  logic        host_cur_kind,
  input  logic [30:0] host_cur_since,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  position,
  output logic        existed,
  output logic        full_res,
  output logic [8:0]  entry_count,
  output logic [63:0] out_host_id,
  output logic [31:0] out_period_start,
  output logic [63:0] out_maint_id,
  output logic        out_maint_kind,
  output logic [63:0] out_host_cur_maint_id,
  output logic        out_host_cur_status,
  output logic        out_host_cur_kind,
  output logic [30:0] out_host_cur_since
);
  import stkt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_SEL  = 5'b00100,
    S_RED1 = 5'b01000,
    S_RED2 = 5'b10000
  } state_t;

  state_t           state, state_next;
  cmd_t             cmd;
  entry_t           new_ent;
  logic [7:0]       rd_idx;
  logic [CNT_W-1:0] count, count_next;
  logic             hit_q, full_q;
  logic             hit_any, full_now;
  logic             accept, finish;
  cell_bc_t         bc;

  entry_t           cell_ent  [DEPTH];
  logic [DEPTH-1:0] below_vec;
  logic [DEPTH-1:0] hit_vec;
  cell_out_t        cell_q    [DEPTH];
  cell_out_t        grp       [NGRP];
  cell_out_t        red;

  logic [8:0]       pos_o;
  logic             ex_o, full_o;
  entry_t           ent_o;
  logic [CNT_W-1:0] pos_sel;
  logic [CNT_W+8:0] pos_w, cnt_w;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign finish   = (state == S_RED2) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd                       <= cmd_t'(command);
      new_ent.host_id           <= host_id;
      new_ent.period_start      <= period_start;
      new_ent.maint_id          <= maint_id;
      new_ent.maint_kind        <= maint_kind;
      new_ent.host_cur_maint_id <= host_cur_maint_id;
      new_ent.host_cur_status   <= host_cur_status;
      new_ent.host_cur_kind     <= host_cur_kind;
      new_ent.host_cur_since    <= host_cur_since;
      rd_idx                    <= read_index;
    end
  end

  assign hit_any  = |hit_vec;
  assign full_now = (count >= CNT_W'(DEPTH)) && !hit_any;

  always_comb begin
    bc.cmd        = cmd;
    bc.ent        = new_ent;
    bc.read_index = rd_idx;
    bc.count      = count;
    bc.cmp_en     = (state == S_CMP);
    bc.sel_en     = (state == S_SEL);
    bc.do_write   = (state == S_SEL) && (cmd == CMD_INSERT) && !hit_any && !full_now;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_below;
    entry_t prev_ent;
    if (i == 0) begin : g_head
      assign prev_below = 1'b1;
      assign prev_ent   = '0;
    end else begin : g_link
      assign prev_below = below_vec[i-1];
      assign prev_ent   = cell_ent[i-1];
    end
    stkt_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .bc         (bc),
      .prev_below (prev_below),
      .prev_ent   (prev_ent),
      .below      (below_vec[i]),
      .ent        (cell_ent[i]),
      .hit        (hit_vec[i]),
      .sel_q      (cell_q[i])
    );
  end

  stkt_reduce u_reduce (
    .clk   (clk),
    .en    (state == S_RED1),
    .cells (cell_q),
    .grp   (grp)
  );

  always_comb begin
    red = '0;
    for (int g = 0; g < NGRP; g++) begin
      red = cell_out_t'(red | grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SEL) begin
      hit_q  <= hit_any;
      full_q <= (cmd == CMD_INSERT) && full_now;
    end
  end

  // no place cell only when the table is full and every key is below
  assign pos_sel = red.place ? CNT_W'(red.pidx) : count;

  always_comb begin
    pos_o      = '0;
    ex_o       = 1'b0;
    full_o     = 1'b0;
    ent_o      = '0;
    count_next = count;
    pos_w      = {9'd0, pos_sel};
    case (cmd)
      CMD_INSERT: begin
        ex_o   = hit_q;
        full_o = full_q;
        pos_o  = pos_w[8:0];
        if (hit_q) begin
          ent_o = red.entry;
        end else if (!full_q) begin
          ent_o      = new_ent;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      CMD_READ: begin
        pos_o = {1'b0, rd_idx};
        ent_o = red.entry;
      end
      default: begin
        pos_o = '0;
      end
    endcase
    cnt_w = {9'd0, count_next};
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CMP;
      S_CMP:   state_next = S_SEL;
      S_SEL:   state_next = S_RED1;
      S_RED1:  state_next = S_RED2;
      S_RED2:  if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      position              <= pos_o;
      existed               <= ex_o;
      full_res              <= full_o;
      entry_count           <= cnt_w[8:0];
      out_host_id           <= ent_o.host_id;
      out_period_start      <= ent_o.period_start;
      out_maint_id          <= ent_o.maint_id;
      out_maint_kind        <= ent_o.maint_kind;
      out_host_cur_maint_id <= ent_o.host_cur_maint_id;
      out_host_cur_status   <= ent_o.host_cur_status;
      out_host_cur_kind     <= ent_o.host_cur_kind;
      out_host_cur_since    <= ent_o.host_cur_since;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_CMP)
    else $error("accepted item did not start compare");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_SEL |-> $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  a_hit_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_RED2 |-> !(hit_q && full_q))
    else $error("hit and full flagged together");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> $past(state == S_RED2))
    else $error("entry count changed outside result step");
`endif

endmodule
